@@ hdl/slot_pool_allocator_top_assert.svh @@
// Assertion macros shared by the slot pool allocator RTL.
`ifndef SLOT_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define SLOT_POOL_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define SLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define SLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/slp_pkg.sv @@
// Shared constants, codes and interface structs of the slot pool allocator.
package slp_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int CAP_W     = 11;
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = $clog2(ROW_W);
  localparam int ROWS      = SLOTS / ROW_W;
  localparam int ROW_IDX_W = $clog2(ROWS);

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (SLOT_W + 1 + CNT_W);

  localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(SLOTS);
  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2,
    OP_CHECK    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ALU_LT      = 2'd0,
    ALU_INC     = 2'd1,
    ALU_INC_SAT = 2'd2,
    ALU_DEC_SAT = 2'd3
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             lt;
    logic [CNT_W-1:0] sum;
  } alu_rsp_t;

  typedef struct packed {
    logic                 rd_en;
    logic [ROW_IDX_W-1:0] rd_row;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_row;
    logic [ROW_W-1:0]     wdata;
    logic                 clr_all;
  } map_req_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0]  wdata;
  } link_req_t;

endpackage

@@ hdl/slp_alu.sv @@
// Shared compare and increment/decrement unit used by the sequencer.
module slp_alu
  import slp_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  always_comb begin
    rsp.lt = (req.a < req.b);
    unique case (req.op)
      ALU_LT:      rsp.sum = req.a;
      ALU_INC:     rsp.sum = req.a + CNT_W'(1);
      ALU_INC_SAT: rsp.sum = (req.a == req.b) ? req.a : req.a + CNT_W'(1);
      ALU_DEC_SAT: rsp.sum = (req.a == '0) ? req.a : req.a - CNT_W'(1);
      default:     rsp.sum = req.a;
    endcase
  end

endmodule

@@ hdl/slp_free_map.sv @@
// Free-list membership bitmap: a row memory with one valid flag per row.
module slp_free_map
  import slp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  map_req_t         req,
  output logic [ROW_W-1:0] rd_data
);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [ROW_W-1:0] rd_raw;
  logic             rd_vld;

  // Rows never written since the last clear read as all zero.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_raw <= mem[req.rd_row];
      rd_vld <= row_valid[req.rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr_all) begin
      row_valid <= '0;
    end else if (req.wr_en) begin
      row_valid[req.wr_row] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

@@ hdl/slp_link_ram.sv @@
// Link memory holding the next entry of each slot on the free list.
module slp_link_ram
  import slp_pkg::*;
(
  input  logic             clk,
  input  link_req_t        req,
  output logic [CNT_W-1:0] rd_data
);

  logic [CNT_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

@@ hdl/slot_pool_allocator_top.sv @@
// Top level of the slot pool allocator: sequencer, state registers and ports.
//
//   channel   direction  handshake          payload
//   cfg       in         cfg_wr_en          cfg_wr_data = capacity_in_use
//   s_*       in         s_tvalid/s_tready  s_tdata = operation, slot
//   m_*       out        m_tvalid/m_tready  m_tdata = granted_slot, ok, slots_in_use
//
// One word is in work at a time; s_tready is high only while the sequencer is idle.
// Allocate and free pass through the read, evaluate, count and done steps; check and
// failed operations skip the count step, and free-all goes from read to done.
// The steps are set by the single shared compare/increment unit, used once per step,
// and the registered read of the memories.
// Reset (rst, synchronous) empties the pool and sets the capacity to 1024; no clearing
// pass is needed because the membership bitmap carries one valid flag per row.
// A result waiting on m_tready holds the sequencer in its final step only when the
// output register is still occupied by the previous word.
`include "slot_pool_allocator_top_assert.svh"

module slot_pool_allocator_top
  import slp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // Bits from the lowest up: operation [1:0], slot [11:2], zero fill [15:12].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // Bits from the lowest up: granted_slot [9:0], ok [10], slots_in_use [21:11],
  // zero fill [23:22].
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_COUNT,
    S_DONE
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  cap_reg;
  logic [CNT_W-1:0]  free_head;
  logic [CNT_W-1:0]  next_fresh;
  logic [CNT_W-1:0]  use_count;
  op_t               op_r;
  logic [SLOT_W-1:0] slot_r;
  logic              lt_r;
  logic              ok_r;
  logic [SLOT_W-1:0] granted_r;

  logic [CNT_W-1:0]     cap_eff;
  logic [SLOT_W-1:0]    target;
  logic [ROW_IDX_W-1:0] target_row;
  logic [ROW_BIT_W-1:0] target_bit;
  logic                 list_nonempty;
  logic                 map_bit;
  logic                 free_ok;
  logic [ROW_W-1:0]     map_rd;
  logic [ROW_W-1:0]     map_new;
  logic [CNT_W-1:0]     link_rd;

  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  map_req_t  map_req;
  link_req_t link_req;

  // Capacity values above the pool size act as the pool size.
  assign cap_eff = (cap_reg > CAP_W'(EMPTY_MARK)) ? EMPTY_MARK : CNT_W'(cap_reg);

  // Allocate works on the list head; free and check work on the requested slot.
  assign target        = (op_r == OP_ALLOC) ? free_head[SLOT_W-1:0] : slot_r;
  assign target_row    = target[SLOT_W-1:ROW_BIT_W];
  assign target_bit    = target[ROW_BIT_W-1:0];
  assign list_nonempty = (free_head != EMPTY_MARK);
  assign map_bit       = map_rd[target_bit];

  // A slot may be freed, or reports valid, when it lies below the capacity
  // and is not already on the free list.
  assign free_ok = lt_r && !map_bit;

  always_comb begin
    map_new             = map_rd;
    map_new[target_bit] = (op_r == OP_FREE);
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    alu_req.op = ALU_LT;
    alu_req.a  = (op_r == OP_ALLOC) ? next_fresh : CNT_W'(slot_r);
    alu_req.b  = cap_eff;
    unique case (state)
      S_EVAL: begin
        alu_req.op = ALU_INC;
        alu_req.a  = next_fresh;
      end
      S_COUNT: begin
        alu_req.op = (op_r == OP_ALLOC) ? ALU_INC_SAT : ALU_DEC_SAT;
        alu_req.a  = use_count;
        alu_req.b  = EMPTY_MARK;
      end
      default: begin
        alu_req.op = ALU_LT;
      end
    endcase
  end

  always_comb begin
    map_req.rd_en   = (state == S_READ);
    map_req.rd_row  = target_row;
    map_req.wr_en   = (state == S_EVAL) &&
                      (((op_r == OP_ALLOC) && list_nonempty) ||
                       ((op_r == OP_FREE) && free_ok));
    map_req.wr_row  = target_row;
    map_req.wdata   = map_new;
    map_req.clr_all = (state == S_READ) && (op_r == OP_FREE_ALL);
  end

  always_comb begin
    link_req.rd_en = (state == S_READ);
    link_req.wr_en = (state == S_EVAL) && (op_r == OP_FREE) && free_ok;
    link_req.addr  = target;
    link_req.wdata = free_head;
  end

  slp_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  slp_free_map u_free_map (
    .clk     (clk),
    .rst     (rst),
    .req     (map_req),
    .rd_data (map_rd)
  );

  slp_link_ram u_link_ram (
    .clk     (clk),
    .req     (link_req),
    .rd_data (link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      cap_reg    <= CAP_RESET;
      free_head  <= EMPTY_MARK;
      next_fresh <= '0;
      use_count  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_reg <= cfg_wr_data;
      end
      // In the final step the output register is reloaded instead.
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r   <= op_t'(s_tdata[1:0]);
            slot_r <= s_tdata[SLOT_W+1:2];
            state  <= S_READ;
          end
        end
        // Memory reads are issued here; the unit compares against the capacity.
        S_READ: begin
          lt_r      <= alu_rsp.lt;
          granted_r <= '0;
          ok_r      <= (op_r == OP_FREE_ALL);
          if (op_r == OP_FREE_ALL) begin
            next_fresh <= '0;
            free_head  <= EMPTY_MARK;
            use_count  <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (op_r)
            OP_ALLOC: begin
              if (list_nonempty) begin
                granted_r <= free_head[SLOT_W-1:0];
                free_head <= link_rd;
                ok_r      <= 1'b1;
                state     <= S_COUNT;
              end else if (lt_r) begin
                granted_r  <= next_fresh[SLOT_W-1:0];
                next_fresh <= alu_rsp.sum;
                ok_r       <= 1'b1;
                state      <= S_COUNT;
              end else begin
                state <= S_DONE;
              end
            end
            OP_FREE: begin
              if (free_ok) begin
                free_head <= CNT_W'(slot_r);
                ok_r      <= 1'b1;
                state     <= S_COUNT;
              end else begin
                state <= S_DONE;
              end
            end
            OP_CHECK: begin
              ok_r  <= free_ok;
              state <= S_DONE;
            end
            default: begin
              ok_r  <= 1'b1;
              state <= S_DONE;
            end
          endcase
        end
        S_COUNT: begin
          use_count <= alu_rsp.sum;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{OUT_PAD_W{1'b0}}, use_count, ok_r, granted_r};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SLP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `SLP_ASSERT_NOW(a_head_range, 1'b1, free_head <= EMPTY_MARK, "free list head out of range")
  `SLP_ASSERT_NOW(a_count_range, 1'b1, use_count <= EMPTY_MARK, "use count above pool size")
  `SLP_ASSERT_NOW(a_map_exclusive, map_req.clr_all, !map_req.wr_en && !link_req.wr_en, "clear")
  `SLP_ASSERT_NOW(a_out_from_done, $rose(m_tvalid), $past(state == S_DONE), "stray result")

endmodule

@@ bench/slot_pool_allocator_checker.sv @@
`timescale 1ns / 100ps
// Checker for the slot pool allocator: predicts every result word and compares it.
module slot_pool_allocator_checker
  import slp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CAP_W-1:0]       cfg_wr_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // Bits from the lowest up: operation [1:0], slot [11:2], zero fill [15:12].
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // Bits from the lowest up: granted_slot [9:0], ok [10], slots_in_use [21:11],
  // zero fill [23:22].
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     outstanding,
  output int                     mismatches
);

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              ok;
    logic [CNT_W-1:0]  slots_in_use;
  } outcome_t;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] fresh_ptr;
  logic [CNT_W-1:0] list_head;
  logic [CNT_W-1:0] in_use;
  logic [CNT_W-1:0] link_mem [SLOTS];
  // One flag per slot that mirrors membership of the free list, so that the
  // double-free test needs no walk of the list.
  bit               listed [SLOTS];
  outcome_t         pending_outcomes [$];
  int               fail_count = 0;

  function automatic logic [CNT_W-1:0] usable_slots();
    return (capacity > CAP_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(capacity);
  endfunction

  function automatic bit can_release(logic [SLOT_W-1:0] slot);
    return (CNT_W'(slot) < usable_slots()) && !listed[slot];
  endfunction

  function automatic outcome_t apply_operation(op_t op, logic [SLOT_W-1:0] slot);
    outcome_t res;
    res = '0;
    case (op)
      OP_ALLOC: begin
        if (list_head < CNT_W'(SLOTS)) begin
          res.granted_slot = list_head[SLOT_W-1:0];
          listed[list_head[SLOT_W-1:0]] = 1'b0;
          list_head = link_mem[list_head[SLOT_W-1:0]];
          res.ok = 1'b1;
        end else if (fresh_ptr < usable_slots()) begin
          res.granted_slot = fresh_ptr[SLOT_W-1:0];
          fresh_ptr = fresh_ptr + CNT_W'(1);
          res.ok = 1'b1;
        end
        if (res.ok && in_use < CNT_W'(SLOTS)) begin
          in_use = in_use + CNT_W'(1);
        end
      end
      OP_FREE: begin
        if (can_release(slot)) begin
          link_mem[slot] = list_head;
          list_head = CNT_W'(slot);
          listed[slot] = 1'b1;
          if (in_use != '0) begin
            in_use = in_use - CNT_W'(1);
          end
          res.ok = 1'b1;
        end
      end
      OP_FREE_ALL: begin
        fresh_ptr = '0;
        list_head = EMPTY_MARK;
        in_use = '0;
        foreach (listed[i]) listed[i] = 1'b0;
        res.ok = 1'b1;
      end
      default: begin
        res.ok = can_release(slot);
      end
    endcase
    res.slots_in_use = in_use;
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      capacity = CAP_RESET;
      fresh_ptr = '0;
      list_head = EMPTY_MARK;
      in_use = '0;
      foreach (listed[i]) listed[i] = 1'b0;
      pending_outcomes.delete();
    end else begin
      // Results are handled before new words so that a stray result is never
      // paired with an expectation pushed at the same edge.
      if (m_tvalid && m_tready) begin
        got.granted_slot = m_tdata[SLOT_W-1:0];
        got.ok = m_tdata[SLOT_W];
        got.slots_in_use = m_tdata[SLOT_W+CNT_W:SLOT_W+1];
        if (pending_outcomes.size() == 0) begin
          $error("result word with nothing expected: %h", m_tdata);
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, actual %0d", want.granted_slot,
                   got.granted_slot);
            fail_count++;
          end
          if (got.ok !== want.ok) begin
            $error("ok: expected %0d, actual %0d", want.ok, got.ok);
            fail_count++;
          end
          if (got.slots_in_use !== want.slots_in_use) begin
            $error("slots_in_use: expected %0d, actual %0d", want.slots_in_use,
                   got.slots_in_use);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        capacity = cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        pending_outcomes.push_back(apply_operation(op_t'(s_tdata[1:0]),
                                                   s_tdata[SLOT_W+1:2]));
      end
    end
    outstanding <= pending_outcomes.size();
    mismatches <= fail_count;
  end

endmodule

@@ bench/tb_slot_pool_allocator_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the slot pool allocator: clock, reset, stimulus and verdict.
module tb_slot_pool_allocator_top;
  import slp_pkg::*;

  // All block inputs start at known values; reset is high from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // Bits from the lowest up: operation [1:0], slot [11:2], zero fill [15:12].
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // Bits from the lowest up: granted_slot [9:0], ok [10], slots_in_use [21:11],
  // zero fill [23:22].
  logic [OUT_TDATA_W-1:0] m_tdata;

  int outstanding;
  int mismatches;

  // Allocations issued since the last free-all. It steers the slots chosen
  // for free and check toward the range that is actually in use.
  int handed_out = 0;

  always #2 clk = ~clk;

  slot_pool_allocator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  slot_pool_allocator_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .outstanding(outstanding),
    .mismatches (mismatches)
  );

  // Idle length for either side: mostly none or a few cycles, now and then a
  // long pause so that gaps land on every step of the sequencer.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 88) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Offers one word and returns at the edge where it is accepted. tvalid is
  // only lowered when an idle gap is wanted, so back-to-back words keep it high.
  task automatic send_word(input op_t op, input logic [SLOT_W-1:0] slot,
                           input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_cycles();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_TDATA_W'({slot, op});
    do @(posedge clk); while (!s_tready);
    if (op == OP_ALLOC && handed_out < SLOTS - 1) begin
      handed_out++;
    end else if (op == OP_FREE_ALL) begin
      handed_out = 0;
    end
  endtask

  // The capacity register is written only once every result has been taken,
  // so the block is idle. Every word yields a result, so nothing else is
  // still in work at that point.
  task automatic set_capacity(input logic [CAP_W-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Receiver: random back-pressure with quiet stretches, plus one long hold
  // after a few hundred words. During that hold the sender keeps offering,
  // the single word in work cannot leave, and s_tready stays low.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned words_taken;
    int unsigned cycle_no;
    bit          long_hold_done;
    stall_left = 0;
    words_taken = 0;
    cycle_no = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (m_tvalid && m_tready) begin
        words_taken++;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && words_taken >= 300) begin
        long_hold_done = 1'b1;
        stall_left = 400;
        m_tready <= 1'b0;
      end else if ((cycle_no / 256) % 4 == 1) begin
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 30) begin
        stall_left = idle_cycles();
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Generous limit on the whole run.
  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [CAP_W-1:0]  phase_caps [10];
    logic [SLOT_W-1:0] pick;
    int unsigned       roll;
    int unsigned       span;
    bit                steady;
    phase_caps = '{11'd16, 11'd1024, 11'd3, 11'd0, 11'd2047,
                   11'd64, 11'd1, 11'd1024, 11'd1500, 11'd8};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of 1024. A slot that was never
    // handed out still counts as valid, and freeing it pushes it on the list.
    send_word(OP_CHECK, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_CHECK, 10'd1, 1'b0);
    send_word(OP_FREE, 10'd1, 1'b0);
    // Double free of the same slot must fail.
    send_word(OP_FREE, 10'd1, 1'b0);
    send_word(OP_CHECK, 10'd1, 1'b0);
    send_word(OP_FREE, 10'd1023, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd1023, 1'b0);
    send_word(OP_FREE_ALL, 10'd1023, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);

    // Capacity of one: the pool fills after a single slot.
    set_capacity(11'd1);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_FREE, 10'd1, 1'b0);
    send_word(OP_FREE, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_FREE, 10'd0, 1'b0);

    // Capacity of zero: every slot is invalid, yet the entry still on the
    // free list is handed out once.
    set_capacity(11'd0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_CHECK, 10'd0, 1'b0);
    send_word(OP_FREE, 10'd0, 1'b0);

    // Out-of-range capacity is clamped to the full pool.
    set_capacity(11'd2047);
    send_word(OP_CHECK, 10'd1023, 1'b0);
    send_word(OP_FREE, 10'd1023, 1'b0);
    send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_FREE_ALL, 10'd0, 1'b0);

    // Counter saturation: freeing an unallocated slot at a count of zero
    // leaves the count at zero, so one allocation more than the pool holds
    // drives the count to its upper bound and one more fails.
    set_capacity(11'd1024);
    send_word(OP_FREE, 10'd0, 1'b0);
    send_word(OP_FREE, 10'd0, 1'b0);
    repeat (SLOTS + 2) send_word(OP_ALLOC, 10'd0, 1'b0);
    send_word(OP_FREE, 10'd5, 1'b0);
    send_word(OP_CHECK, 10'd5, 1'b0);
    send_word(OP_FREE_ALL, 10'd0, 1'b0);

    // Random part in phases of different capacities. Phases are not separated
    // by a free-all, so a lowered capacity meets slots still on the list.
    for (int p = 0; p < 10; p++) begin
      set_capacity(phase_caps[p]);
      for (int i = 0; i < 34; i++) begin
        steady = ((i / 8) % 4 == 2);
        roll = $urandom_range(0, 99);
        span = (handed_out + 2 < SLOTS) ? handed_out + 2 : SLOTS - 1;
        if ($urandom_range(0, 3) == 0) begin
          pick = SLOT_W'($urandom_range(0, SLOTS - 1));
        end else begin
          pick = SLOT_W'($urandom_range(0, span));
        end
        if (roll < 42) begin
          send_word(OP_ALLOC, SLOT_W'($urandom_range(0, SLOTS - 1)), steady);
        end else if (roll < 72) begin
          send_word(OP_FREE, pick, steady);
        end else if (roll < 76) begin
          send_word(OP_FREE_ALL, SLOT_W'($urandom_range(0, SLOTS - 1)), steady);
        end else if (roll < 95) begin
          send_word(OP_CHECK, pick, steady);
        end else begin
          send_word(op_t'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, SLOTS - 1)),
                    steady);
        end
      end
    end

    // Drain: wait for every expected word, then a short tail so that any
    // stray result would still be seen.
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
